/* rtl/lags_pkg.sv */
// ----------------------------------------------------------------------------
// Lattice animal growth stack package
// Shared constants, action and status codes, and the storage request and read types.
// ----------------------------------------------------------------------------
package lags_pkg;

	localparam int CELLS     = 1024;
	localparam int CELL_W    = $clog2(CELLS);
	localparam int MAX_NBR   = 8;
	localparam int SLOT_W    = $clog2(MAX_NBR);
	localparam int LEN_W     = $clog2(MAX_NBR + 1);
	localparam int STK_DEPTH = 64;
	localparam int STK_W     = $clog2(STK_DEPTH);
	localparam int CNT_W     = $clog2(STK_DEPTH + 1);
	localparam int NT_AW     = CELL_W + SLOT_W;
	localparam int SIZE_W    = 7;
	localparam int NCNT_W    = 4;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_POP   = 2'd2;
	localparam logic [1:0] ACT_QUERY = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_OCC   = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	typedef struct packed {
		logic              occ_we;
		logic [CELL_W-1:0] occ_waddr;
		logic              occ_wdata;
		logic [CELL_W-1:0] occ_raddr;
		logic              len_we;
		logic [CELL_W-1:0] len_waddr;
		logic [LEN_W-1:0]  len_wdata;
		logic [CELL_W-1:0] len_raddr;
		logic              nt_we;
		logic [NT_AW-1:0]  nt_waddr;
		logic [CELL_W-1:0] nt_wdata;
		logic [NT_AW-1:0]  nt_raddr;
		logic              stk_we;
		logic [STK_W-1:0]  stk_waddr;
		logic [CELL_W-1:0] stk_wdata;
		logic [STK_W-1:0]  stk_raddr;
	} mem_req_t;

	typedef struct packed {
		logic              occ;
		logic [LEN_W-1:0]  len;
		logic [CELL_W-1:0] nt;
		logic [CELL_W-1:0] stk;
	} mem_rd_t;

endpackage

/* rtl/lags_if.sv */
// ----------------------------------------------------------------------------
// Lattice animal growth stack channels
// Command and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lags_cmd_if;
	import lags_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [CELL_W-1:0] cell_req;
	logic [2:0]        slot;
	logic [CELL_W-1:0] neighbour_cell;
	logic [NCNT_W-1:0] neighbour_count;

	modport source (output valid, action, cell_req, slot, neighbour_cell, neighbour_count,
		input ready);
	modport sink (input valid, action, cell_req, slot, neighbour_cell, neighbour_count,
		output ready);
endinterface

interface lags_res_if;
	import lags_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [CELL_W-1:0] candidate_cell;
	logic              candidate_valid;
	logic              last;
	logic [CNT_W-1:0]  depth;

	modport source (output valid, status, candidate_cell, candidate_valid, last, depth,
		input ready);
	modport sink (input valid, status, candidate_cell, candidate_valid, last, depth,
		output ready);
endinterface

/* rtl/lattice_animal_growth_stack_unit.sv */
// ----------------------------------------------------------------------------
// Lattice animal growth stack unit
// Occupancy map, cell stack and neighbour table for growing lattice animals.
// ----------------------------------------------------------------------------
// After reset the unit clears all 1024 entries of the occupancy map and the
// list lengths and takes no command word meanwhile. It then handles one
// command at a time through a small sequencer around the registered read
// ports of its memories. A load, an add or a pop passes one sequencer state
// before its result; a query reads the top cell and its list length, then for
// each neighbour of the top cell reads it, skips it when occupied, tests each
// cell of that neighbour's own list for occupancy by a cell other than the top
// one and passes on the neighbour as a candidate when none is. Result words
// wait in an output register; a stalled result channel holds the sequencer.
module lattice_animal_growth_stack_unit
	import lags_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [SIZE_W-1:0] cfg_wr_data,
	lags_cmd_if.sink          cmd,
	lags_res_if.source        res
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RESP  = 4'd1;
	localparam logic [3:0] S_ADD   = 4'd2;
	localparam logic [3:0] S_POP   = 4'd3;
	localparam logic [3:0] S_QTOP  = 4'd4;
	localparam logic [3:0] S_QLEN  = 4'd5;
	localparam logic [3:0] S_QCAND = 4'd6;
	localparam logic [3:0] S_QCOCC = 4'd7;
	localparam logic [3:0] S_QNB   = 4'd8;
	localparam logic [3:0] S_QNOCC = 4'd9;
	localparam logic [3:0] S_QGOOD = 4'd10;
	localparam logic [3:0] S_QNEXT = 4'd11;
	localparam logic [3:0] S_QEND  = 4'd12;

	mem_req_t req;
	mem_rd_t  rd;
	logic     clr_busy;

	logic [3:0]        state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [SIZE_W-1:0] size_q;
	logic              pend_v_q, pend_v_d;
	logic [CELL_W-1:0] pend_c_q, pend_c_d;
	logic [CELL_W-1:0] cell_q, cell_d;
	logic [1:0]        stat_q, stat_d;
	logic [CELL_W-1:0] top_q, top_d;
	logic [CELL_W-1:0] c_q, c_d;
	logic [CELL_W-1:0] m_q, m_d;
	logic [LEN_W-1:0]  n_q, n_d;
	logic [LEN_W-1:0]  cn_q, cn_d;
	logic [LEN_W-1:0]  i_q, i_d;
	logic [LEN_W-1:0]  j_q, j_d;

	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [CELL_W-1:0] out_cand_q;
	logic              out_cvalid_q;
	logic              out_last_q;
	logic [CNT_W-1:0]  out_depth_q;

	logic              out_free;
	logic              out_load;
	logic [1:0]        o_status;
	logic [CELL_W-1:0] o_cand;
	logic              o_cvalid;
	logic              o_last;
	logic [CNT_W-1:0]  o_depth;

	logic              cmd_acc;
	logic              stack_full;
	logic [CNT_W-1:0]  count_m1;
	logic [CNT_W-1:0]  count_p1;
	logic [LEN_W-1:0]  i_p1;
	logic [LEN_W-1:0]  j_p1;
	logic [LEN_W-1:0]  len_clamp;

	lags_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rd     (rd),
		.busy   (clr_busy)
	);

	assign cmd.ready  = (state_q == S_IDLE) && !clr_busy;
	assign cmd_acc    = cmd.valid && cmd.ready;
	assign out_free   = !out_valid_q || res.ready;
	assign count_m1   = count_q - CNT_W'(1);
	assign count_p1   = count_q + CNT_W'(1);
	assign i_p1       = i_q + LEN_W'(1);
	assign j_p1       = j_q + LEN_W'(1);
	assign stack_full = ({1'b0, count_q} >= (CNT_W + 1)'(size_q)) ||
		(count_q >= CNT_W'(STK_DEPTH));
	assign len_clamp  = (cmd.neighbour_count > NCNT_W'(MAX_NBR)) ? LEN_W'(MAX_NBR) :
		LEN_W'(cmd.neighbour_count);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		pend_v_d = pend_v_q;
		pend_c_d = pend_c_q;
		cell_d   = cell_q;
		stat_d   = stat_q;
		top_d    = top_q;
		c_d      = c_q;
		m_d      = m_q;
		n_d      = n_q;
		cn_d     = cn_q;
		i_d      = i_q;
		j_d      = j_q;
		req      = '0;
		out_load = 1'b0;
		o_status = STAT_OK;
		o_cand   = '0;
		o_cvalid = 1'b0;
		o_last   = 1'b1;
		o_depth  = count_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					cell_d   = cmd.cell_req;
					stat_d   = STAT_OK;
					pend_v_d = 1'b0;
					unique case (cmd.action)
						ACT_LOAD: begin
							req.nt_we     = 1'b1;
							req.nt_waddr  = {cmd.cell_req, cmd.slot};
							req.nt_wdata  = cmd.neighbour_cell;
							req.len_we    = 1'b1;
							req.len_waddr = cmd.cell_req;
							req.len_wdata = len_clamp;
							state_d       = S_RESP;
						end
						ACT_ADD: begin
							if (stack_full) begin
								stat_d  = STAT_FULL;
								state_d = S_RESP;
							end else begin
								req.occ_raddr = cmd.cell_req;
								state_d       = S_ADD;
							end
						end
						default: begin
							if (count_q == '0) begin
								stat_d  = STAT_EMPTY;
								state_d = S_RESP;
							end else begin
								req.stk_raddr = count_m1[STK_W-1:0];
								state_d = (cmd.action == ACT_POP) ? S_POP : S_QTOP;
							end
						end
					endcase
				end
			end
			S_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					o_status = stat_q;
					state_d  = S_IDLE;
				end
			end
			S_ADD: begin
				req.occ_raddr = cell_q;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
					if (rd.occ) begin
						o_status = STAT_OCC;
					end else begin
						req.occ_we    = 1'b1;
						req.occ_waddr = cell_q;
						req.occ_wdata = 1'b1;
						req.stk_we    = 1'b1;
						req.stk_waddr = count_q[STK_W-1:0];
						req.stk_wdata = cell_q;
						count_d       = count_p1;
						o_depth       = count_p1;
					end
				end
			end
			S_POP: begin
				req.stk_raddr = count_m1[STK_W-1:0];
				if (out_free) begin
					req.occ_we    = 1'b1;
					req.occ_waddr = rd.stk;
					req.occ_wdata = 1'b0;
					count_d       = count_m1;
					o_depth       = count_m1;
					out_load      = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_QTOP: begin
				top_d         = rd.stk;
				req.len_raddr = rd.stk;
				state_d       = S_QLEN;
			end
			S_QLEN: begin
				n_d = rd.len;
				i_d = '0;
				if (rd.len == '0) begin
					state_d = S_QEND;
				end else begin
					req.nt_raddr = {top_q, SLOT_W'(0)};
					state_d      = S_QCAND;
				end
			end
			S_QCAND: begin
				c_d           = rd.nt;
				req.occ_raddr = rd.nt;
				req.len_raddr = rd.nt;
				state_d       = S_QCOCC;
			end
			S_QCOCC: begin
				if (rd.occ) begin
					state_d = S_QNEXT;
				end else begin
					cn_d = rd.len;
					j_d  = '0;
					if (rd.len == '0) begin
						state_d = S_QGOOD;
					end else begin
						req.nt_raddr = {c_q, SLOT_W'(0)};
						state_d      = S_QNB;
					end
				end
			end
			S_QNB: begin
				m_d           = rd.nt;
				req.occ_raddr = rd.nt;
				state_d       = S_QNOCC;
			end
			S_QNOCC: begin
				if (rd.occ && (m_q != top_q)) begin
					state_d = S_QNEXT;
				end else if (j_p1 == cn_q) begin
					state_d = S_QGOOD;
				end else begin
					j_d          = j_p1;
					req.nt_raddr = {c_q, j_p1[SLOT_W-1:0]};
					state_d      = S_QNB;
				end
			end
			S_QGOOD: begin
				if (!pend_v_q || out_free) begin
					if (pend_v_q) begin
						out_load = 1'b1;
						o_cand   = pend_c_q;
						o_cvalid = 1'b1;
						o_last   = 1'b0;
					end
					pend_v_d = 1'b1;
					pend_c_d = c_q;
					state_d  = S_QNEXT;
				end
			end
			S_QNEXT: begin
				if (i_p1 == n_q) begin
					state_d = S_QEND;
				end else begin
					i_d          = i_p1;
					req.nt_raddr = {top_q, i_p1[SLOT_W-1:0]};
					state_d      = S_QCAND;
				end
			end
			S_QEND: begin
				if (out_free) begin
					out_load = 1'b1;
					if (pend_v_q) begin
						o_cand   = pend_c_q;
						o_cvalid = 1'b1;
					end
					pend_v_d = 1'b0;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			size_q      <= SIZE_RESET;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			pend_v_q <= pend_v_d;
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_c_q <= pend_c_d;
		cell_q   <= cell_d;
		stat_q   <= stat_d;
		top_q    <= top_d;
		c_q      <= c_d;
		m_q      <= m_d;
		n_q      <= n_d;
		cn_q     <= cn_d;
		i_q      <= i_d;
		j_q      <= j_d;
		if (out_load) begin
			out_status_q <= o_status;
			out_cand_q   <= o_cand;
			out_cvalid_q <= o_cvalid;
			out_last_q   <= o_last;
			out_depth_q  <= o_depth;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.status          = out_status_q;
	assign res.candidate_cell  = out_cand_q;
	assign res.candidate_valid = out_cvalid_q;
	assign res.last            = out_last_q;
	assign res.depth           = out_depth_q;

endmodule

/* rtl/lags_store.sv */
// ----------------------------------------------------------------------------
// Lattice animal growth stack storage
// Occupancy, list length, neighbour table and cell stack memories, each with
// one write and one registered read port, plus the clearing pass after reset.
// ----------------------------------------------------------------------------
module lags_store
	import lags_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output mem_rd_t  rd,
	output logic     busy
);

	logic              occ_mem [CELLS];
	logic [LEN_W-1:0]  len_mem [CELLS];
	logic [CELL_W-1:0] nt_mem  [CELLS*MAX_NBR];
	logic [CELL_W-1:0] stk_mem [STK_DEPTH];

	logic              clr_busy_q;
	logic [CELL_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + CELL_W'(1);
			if (clr_addr_q == CELL_W'(CELLS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			occ_mem[clr_addr_q] <= 1'b0;
			len_mem[clr_addr_q] <= '0;
		end else begin
			if (req.occ_we) begin
				occ_mem[req.occ_waddr] <= req.occ_wdata;
			end
			if (req.len_we) begin
				len_mem[req.len_waddr] <= req.len_wdata;
			end
		end
		if (req.nt_we) begin
			nt_mem[req.nt_waddr] <= req.nt_wdata;
		end
		if (req.stk_we) begin
			stk_mem[req.stk_waddr] <= req.stk_wdata;
		end
		rd.occ <= occ_mem[req.occ_raddr];
		rd.len <= len_mem[req.len_raddr];
		rd.nt  <= nt_mem[req.nt_raddr];
		rd.stk <= stk_mem[req.stk_raddr];
	end

	assign busy = clr_busy_q;

endmodule
